>>> src/msr_pkg.sv
// Shared types and constants for the multispecies Ricker step core.
package msr_pkg;

  localparam int MaxSpeciesDef = 4;
  localparam int Ln2Q16        = 45426;
  localparam int ExpTerms      = 8;

  typedef enum logic [1:0] {
    FUNC_LOAD_RATE  = 2'd0,
    FUNC_LOAD_ALPHA = 2'd1,
    FUNC_LOAD_ABUND = 2'd2,
    FUNC_STEP       = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ACC,
    ST_EXPON,
    ST_RANGE,
    ST_TERM_MUL,
    ST_TERM_DIV,
    ST_SCALE,
    ST_PROD,
    ST_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic do_load;
    logic acc_clear;
    logic acc_step;
    logic expon;
    logic range_step;
    logic term_init;
    logic term_mul;
    logic term_div;
    logic scale;
    logic prod;
    logic finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_step;
    logic in_range;
    logic acc_done;
    logic range_done;
    logic term_done;
    logic exp_shortcut;
  } dp_status_t;

endpackage

>>> src/multispecies_ricker_step_core.sv
// Top level of the multispecies Ricker step core.
//  channel | ports                                    | handshake
//  input   | in_func in_species in_other_species ...  | start & !busy
//  result  | out_species out_abundance ...            | out_valid, one cycle
//  config  | cfg_we cfg_species_in_use                | cfg_we
// A load passes through LOAD and FINISH, busy in both, and out_valid is
// registered from FINISH. A step with n species in the sum accumulates n
// products; out of range, the exponent goes straight to scaling, otherwise
// q (0 to 33) range-reduction subtracts and the exp series terms follow.
// Reset is synchronous; state arrays clear to zero, species_in_use to 4.
// The receiver cannot stall; each result beat is shown for one cycle.
module multispecies_ricker_step_core
  import msr_pkg::*;
#(
  parameter int MAX_SPECIES = MaxSpeciesDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_func,
  input  logic [3:0]         in_species,
  input  logic [3:0]         in_other_species,
  input  logic signed [31:0] in_value,
  input  logic signed [31:0] in_noise,
  input  logic               in_last,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_species_in_use,
  output logic               out_valid,
  output logic [3:0]         out_species,
  output logic [31:0]        out_abundance,
  output logic               out_saturated,
  output logic               out_committed
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic [4:0] species_in_use_r;

  always_ff @(posedge clk) begin
    if (!rst_n) species_in_use_r <= 5'd4;
    else if (cfg_we) species_in_use_r <= cfg_species_in_use;
  end

  msr_ctrl u_ctrl (
    .clk, .rst_n, .start, .status, .cmd, .busy, .out_valid
  );

  msr_datapath #(.MAX_SPECIES(MAX_SPECIES)) u_dp (
    .clk, .rst_n, .in_func, .in_species, .in_other_species, .in_value,
    .in_noise, .in_last, .cfg_species_in_use_r(species_in_use_r), .cmd,
    .status, .out_species, .out_abundance, .out_saturated, .out_committed
  );

endmodule

>>> src/msr_datapath.sv
// Datapath: state arrays, dot product, iterative exp and final product.
module msr_datapath
  import msr_pkg::*;
#(
  parameter int MAX_SPECIES = MaxSpeciesDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         in_func,
  input  logic [3:0]         in_species,
  input  logic [3:0]         in_other_species,
  input  logic signed [31:0] in_value,
  input  logic signed [31:0] in_noise,
  input  logic               in_last,
  input  logic [4:0]         cfg_species_in_use_r,
  input  dp_cmd_t            cmd,
  output dp_status_t         status,
  output logic [3:0]         out_species,
  output logic [31:0]        out_abundance,
  output logic               out_saturated,
  output logic               out_committed
);

  localparam int IdxW = (MAX_SPECIES > 1) ? $clog2(MAX_SPECIES) : 1;
  localparam int CntW = $clog2(MAX_SPECIES + 1);
  localparam int NumAlpha = MAX_SPECIES * MAX_SPECIES;
  localparam int AlphaW = (NumAlpha > 1) ? $clog2(NumAlpha) : 1;

  // ceil(2^33 / d), exact floor division of any 30-bit value by d
  localparam logic [31:0] Recip3 = 32'd2863311531;
  localparam logic [31:0] Recip5 = 32'd1717986919;
  localparam logic [31:0] Recip6 = 32'd1431655766;
  localparam logic [31:0] Recip7 = 32'd1227133514;

  logic [31:0] now_r  [MAX_SPECIES];
  logic [31:0] next_r [MAX_SPECIES];
  logic [31:0] rate_r [MAX_SPECIES];
  logic [31:0] alpha_r [NumAlpha];

  // captured item
  logic [1:0]         func_r;
  logic [3:0]         sp_r;
  logic [3:0]         other_r;
  logic signed [31:0] val_r;
  logic signed [31:0] noise_r;
  logic               last_r;

  logic [CntW-1:0]    k_r;
  logic [CntW-1:0]    n_lim;
  logic signed [63:0] acc_r;
  logic signed [63:0] e_r;
  logic [35:0]        u_r;       // e - lo, known below 34*Ln2
  logic [5:0]         kq_r;      // floor quotient of u
  logic [29:0]        x_r;       // f << 14
  logic [30:0]        term_r;
  logic [60:0]        tprod_r;
  logic [3:0]         ti_r;
  logic [47:0]        sum_r;
  logic [31:0]        ex_r;
  logic               sat_r;
  logic [63:0]        prod_r;

  logic in_range_c, alpha_ok;
  logic [IdxW-1:0] sp_idx, k_idx;
  logic [AlphaW-1:0] alpha_idx;
  logic signed [63:0] term_p;
  logic signed [63:0] floor_p;
  logic [31:0] now_sp;
  logic [47:0] scaled;
  logic [29:0] tq;
  logic [31:0] recip;
  logic [61:0] tq_mul;
  logic [29:0] tquot;

  assign in_range_c = ({28'd0, sp_r} < MAX_SPECIES);
  assign alpha_ok   = in_range_c && ({28'd0, other_r} < MAX_SPECIES);
  assign sp_idx     = sp_r[IdxW-1:0];
  assign k_idx      = k_r[IdxW-1:0];
  assign n_lim = ({27'd0, cfg_species_in_use_r} < MAX_SPECIES) ?
                 CntW'(cfg_species_in_use_r) : CntW'(MAX_SPECIES);
  assign alpha_idx = AlphaW'(32'(k_idx) * MAX_SPECIES + 32'(sp_idx));
  assign now_sp = in_range_c ? now_r[sp_idx] : 32'd0;

  // arithmetic shift right by 16 is the floor for signed values
  assign term_p  = 64'($signed({1'b0, now_r[k_idx]}) *
                       $signed({alpha_r[alpha_idx][31], alpha_r[alpha_idx]}));
  assign floor_p = term_p >>> 16;

  assign status.is_step      = (func_r == FUNC_STEP);
  assign status.in_range     = in_range_c;
  assign status.acc_done     = (k_r >= n_lim);
  assign status.range_done   = (u_r < 36'(Ln2Q16));
  assign status.term_done    = (ti_r == 4'(ExpTerms));
  assign status.exp_shortcut = (e_r >= 64'(16 * Ln2Q16)) || (e_r < -64'(18 * Ln2Q16));

  // scale by 2^(kq - 18) from Q30 down to Q16.16
  always_comb begin
    if (kq_r >= 6'd32) scaled = sum_r << (kq_r - 6'd32);
    else               scaled = sum_r >> (6'd32 - kq_r);
  end

  // divide the series term by its index: shifts for powers of two, else reciprocal
  always_comb begin
    tq = tprod_r[59:30];
    unique case (ti_r)
      4'd3:    recip = Recip3;
      4'd5:    recip = Recip5;
      4'd6:    recip = Recip6;
      4'd7:    recip = Recip7;
      default: recip = 32'd0;
    endcase
    tq_mul = 62'(tq) * 62'(recip);
    unique case (ti_r)
      4'd2:                    tquot = tq >> 1;
      4'd4:                    tquot = tq >> 2;
      4'd8:                    tquot = tq >> 3;
      4'd3, 4'd5, 4'd6, 4'd7:  tquot = 30'(tq_mul >> 33);
      default:                 tquot = tq;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_SPECIES; i++) begin
        now_r[i]  <= '0;
        next_r[i] <= '0;
        rate_r[i] <= '0;
      end
      for (int i = 0; i < NumAlpha; i++) alpha_r[i] <= '0;
      out_committed <= 1'b0;
      out_saturated <= 1'b0;
    end else begin
      if (cmd.capture) begin
        func_r  <= in_func;
        sp_r    <= in_species;
        other_r <= in_other_species;
        val_r   <= in_value;
        noise_r <= in_noise;
        last_r  <= in_last;
        sat_r   <= 1'b0;
      end
      if (cmd.do_load) begin
        unique case (func_t'(func_r))
          FUNC_LOAD_RATE:  if (in_range_c) rate_r[sp_idx] <= val_r;
          FUNC_LOAD_ALPHA: if (alpha_ok)
            alpha_r[AlphaW'(32'(other_r[IdxW-1:0]) * MAX_SPECIES + 32'(sp_idx))] <= val_r;
          FUNC_LOAD_ABUND: if (in_range_c) begin
            now_r[sp_idx]  <= val_r[31] ? 32'd0 : val_r;
            next_r[sp_idx] <= val_r[31] ? 32'd0 : val_r;
          end
          default: ;
        endcase
      end
      if (cmd.acc_clear) begin
        acc_r <= '0;
        k_r   <= '0;
      end
      if (cmd.acc_step) begin
        acc_r <= acc_r + floor_p;
        k_r   <= k_r + 1'b1;
      end
      if (cmd.expon) begin
        e_r <= 64'($signed(rate_r[sp_idx])) + 64'(noise_r) - acc_r;
      end
      if (cmd.term_init) begin
        // leaves shortcut cases; range reduction by repeated subtract
        u_r  <= 36'(e_r + 64'(18 * Ln2Q16));
        kq_r <= '0;
        ti_r <= 4'd0;
      end
      if (cmd.range_step) begin
        u_r  <= u_r - 36'(Ln2Q16);
        kq_r <= kq_r + 6'd1;
      end
      if (cmd.term_mul) begin
        if (ti_r == 4'd0) begin
          x_r    <= {u_r[15:0], 14'd0};
          term_r <= {1'b1, 30'd0};
          sum_r  <= 48'd1 << 30;
          ti_r   <= 4'd1;
          tprod_r <= '0;
        end else begin
          tprod_r <= 61'(term_r) * 61'(x_r);
        end
      end
      if (cmd.term_div) begin
        term_r <= {1'b0, tquot};
        sum_r  <= sum_r + 48'(tquot);
        ti_r   <= ti_r + 4'd1;
      end
      if (cmd.scale) begin
        if (e_r >= 64'(16 * Ln2Q16)) begin
          ex_r <= 32'hFFFF_FFFF; sat_r <= 1'b1;
        end else if (e_r < -64'(18 * Ln2Q16)) begin
          ex_r <= 32'd0;
        end else if (scaled > 48'hFFFF_FFFF) begin
          ex_r <= 32'hFFFF_FFFF; sat_r <= 1'b1;
        end else begin
          ex_r <= scaled[31:0];
        end
      end
      if (cmd.prod) prod_r <= 64'(now_sp) * 64'(ex_r);
      if (cmd.finish) begin
        out_species   <= sp_r;
        out_committed <= status.is_step && last_r;
        if (status.is_step) begin
          if (in_range_c) begin
            if (prod_r[63:48] != 16'd0) begin
              out_abundance <= 32'hFFFF_FFFF;
              out_saturated <= 1'b1;
              next_r[sp_idx] <= 32'hFFFF_FFFF;
            end else begin
              out_abundance <= prod_r[47:16];
              out_saturated <= sat_r;
              next_r[sp_idx] <= prod_r[47:16];
            end
          end else begin
            out_abundance <= 32'd0;
            out_saturated <= 1'b0;
          end
          if (last_r) begin
            for (int i = 0; i < MAX_SPECIES; i++) begin
              if (in_range_c && i == 32'(sp_idx))
                now_r[i] <= (prod_r[63:48] != 16'd0) ? 32'hFFFF_FFFF : prod_r[47:16];
              else
                now_r[i] <= next_r[i];
            end
          end
        end else begin
          out_abundance <= now_sp;
          out_saturated <= 1'b0;
        end
      end
    end
  end

endmodule

>>> src/msr_ctrl.sv
// Controller state machine sequencing loads and step items.
module msr_ctrl
  import msr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       busy,
  output logic       out_valid
);

  state_t state_r, state_nxt;
  logic   tdiv_r, tdiv_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tdiv_r  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tdiv_r  <= tdiv_nxt;
      out_valid <= (state_r == ST_FINISH);
    end
  end

  always_comb begin
    state_nxt = state_r;
    tdiv_nxt  = 1'b0;
    unique case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_LOAD;
      ST_LOAD: begin
        if (status.is_step && status.in_range) state_nxt = ST_ACC;
        else state_nxt = ST_FINISH;
      end
      ST_ACC:   if (status.acc_done) state_nxt = ST_EXPON;
      ST_EXPON: state_nxt = ST_RANGE;
      ST_RANGE: begin
        if (status.exp_shortcut) state_nxt = ST_SCALE;
        else state_nxt = ST_TERM_MUL;
      end
      ST_TERM_MUL: state_nxt = ST_TERM_DIV;
      ST_TERM_DIV: state_nxt = ST_TERM_MUL;
      ST_SCALE:  state_nxt = ST_PROD;
      ST_PROD:   state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
    // range reduction and series live under TERM states via flag
    if (state_r == ST_TERM_MUL && !tdiv_r && !status.range_done) begin
      state_nxt = ST_TERM_MUL;
    end else if (state_r == ST_TERM_MUL && !tdiv_r) begin
      tdiv_nxt  = 1'b1;
      state_nxt = ST_TERM_MUL;
    end else if (state_r == ST_TERM_MUL) begin
      tdiv_nxt  = 1'b1;
      state_nxt = ST_TERM_DIV;
    end else if (state_r == ST_TERM_DIV) begin
      tdiv_nxt  = 1'b1;
      state_nxt = status.term_done ? ST_SCALE : ST_TERM_MUL;
    end
  end

  always_comb begin
    cmd = '0;
    busy = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE:  cmd.capture = start;
      ST_LOAD: begin
        cmd.do_load   = 1'b1;
        cmd.acc_clear = 1'b1;
      end
      ST_ACC:   cmd.acc_step = !status.acc_done;
      ST_EXPON: cmd.expon = 1'b1;
      ST_RANGE: cmd.term_init = 1'b1;
      ST_TERM_MUL: begin
        if (!tdiv_r && !status.range_done) cmd.range_step = 1'b1;
        else cmd.term_mul = 1'b1;
      end
      ST_TERM_DIV: cmd.term_div = 1'b1;
      ST_SCALE:  cmd.scale = 1'b1;
      ST_PROD:   cmd.prod = 1'b1;
      ST_FINISH: cmd.finish = 1'b1;
      default: ;
    endcase
  end

endmodule

>>> src/msr_checker.sv
// Port-level checker bound to the step core.
module msr_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted item did not raise busy");
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result beat lasted two cycles");
  a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("busy while result shown");
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(busy)) else $error("result without item");
endmodule

bind multispecies_ricker_step_core msr_checker u_chk (
  .clk, .rst_n, .start, .busy, .out_valid
);
